>>> src/rpe_pkg.sv
// rpe_pkg: shared types and constants for the raid4 parity engine
// no dependencies; used by every rtl file of the block
`default_nettype none
package rpe_pkg;

   localparam int OFF_W  = 16;
   localparam int DRV_W  = 4;
   localparam int CNT_W  = 5;
   localparam int BS_W   = 13;
   localparam int BS_MAX = 4096;

   typedef enum logic [1:0] {
      CMD_READ    = 2'd0,
      CMD_WRITE   = 2'd1,
      CMD_REBUILD = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_DRIVE_COUNT    = 3'd0,
      CSR_BLOCK_SIZE     = 3'd1,
      CSR_DEGRADED_MODE  = 3'd2,
      CSR_FAILED_DRIVE   = 3'd3,
      CSR_REBUILD_TARGET = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_DIV1,
      F_DIV2,
      F_MUL1,
      F_MUL2,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_DISPATCH,
      B_RD,
      B_WR_OLD,
      B_WR_PAR,
      B_WR_FIN,
      B_SWEEP,
      B_DRAIN,
      B_FINAL,
      B_RESP
   } back_state_type;

   // classified transaction handed from front to back
   typedef struct packed {
      cmd_type           cmd;
      logic              err;
      logic [DRV_W-1:0]  drv;
      logic [OFF_W-1:0]  off;
      logic [7:0]        wb;
   } item_type;

endpackage
`default_nettype wire

>>> src/rpe_divider.sv
// rpe_divider: restoring divider, one quotient bit per cycle
// 16-bit dividend, 13-bit divisor (divisor at most 4096); uses rpe_pkg
`default_nettype none
module rpe_divider (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [15:0]                  dividend,
   input  wire logic [rpe_pkg::BS_W-1:0]     divisor,
   output logic                              done,
   output logic [15:0]                       quotient,
   output logic [rpe_pkg::BS_W-1:0]          remainder
);
   logic [15:0]               quo_ff, quo_in;
   logic [rpe_pkg::BS_W-1:0]  rem_ff, rem_in, div_ff, div_in;
   logic [3:0]                cnt_ff, cnt_in;
   logic                      run_ff, run_in, done_ff, done_in;
   logic [rpe_pkg::BS_W-1:0]  trial;
   logic                      ge;

   // remainder stays below 4096, so its low 12 bits plus the next bit fit
   assign trial = {rem_ff[rpe_pkg::BS_W-2:0], quo_ff[15]};
   assign ge    = trial >= div_ff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[14:0], ge};
         rem_in = ge ? trial - div_ff : trial;
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

>>> src/rpe_front.sv
// rpe_front: accepts commands, maps logical addresses to drive and offset
// uses rpe_pkg and rpe_divider
`default_nettype none
module rpe_front #(
   parameter int DRIVE_BYTES = 4096
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [1:0]                 command,
   input  wire logic [15:0]                address,
   input  wire logic [7:0]                 write_byte,
   input  wire logic [rpe_pkg::CNT_W-1:0]  n_eff,
   input  wire logic [rpe_pkg::BS_W-1:0]   bs_eff,
   input  wire logic                       q_full,
   output logic                            busy,
   output logic                            q_push,
   output rpe_pkg::item_type               q_item
);
   localparam int PROD_W = 30;

   rpe_pkg::front_state_type   state_ff, state_in;
   rpe_pkg::cmd_type           cmd_ff, cmd_in;
   logic [7:0]                 wb_ff, wb_in;
   logic [rpe_pkg::BS_W-1:0]   bs_ff, bs_in;
   logic [rpe_pkg::DRV_W-1:0]  nd_ff, nd_in;
   logic [PROD_W-1:0]          lim_ff, lim_in;
   logic [15:0]                q1_ff, q1_in, q2_ff, q2_in;
   logic [rpe_pkg::BS_W-1:0]   r1_ff, r1_in;
   logic [rpe_pkg::DRV_W-1:0]  drv_ff, drv_in;
   logic [PROD_W-1:0]          off_ff, off_in;
   logic                       err_ff, err_in;
   logic                       div_start, div_done;
   logic [15:0]                div_dividend, div_quo;
   logic [rpe_pkg::BS_W-1:0]   div_divisor, div_rem;
   logic [rpe_pkg::DRV_W-1:0]  nd_new;
   logic [PROD_W-1:0]          cap_prod;

   assign nd_new   = rpe_pkg::DRV_W'(n_eff - rpe_pkg::CNT_W'(1));
   // end of this block, compared against the capacity of the data drives
   assign cap_prod = PROD_W'(({1'b0, q1_ff} + 17'd1) * bs_ff);

   rpe_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      wb_in    = wb_ff;
      bs_in    = bs_ff;
      nd_in    = nd_ff;
      lim_in   = lim_ff;
      q1_in    = q1_ff;
      q2_in    = q2_ff;
      r1_in    = r1_ff;
      drv_in   = drv_ff;
      off_in   = off_ff;
      err_in   = err_ff;
      case (state_ff)
         rpe_pkg::F_IDLE: begin
            if (start) begin
               cmd_in  = rpe_pkg::cmd_type'(command);
               wb_in   = write_byte;
               bs_in   = bs_eff;
               nd_in   = nd_new;
               lim_in  = PROD_W'(nd_new * DRIVE_BYTES);
               drv_in  = '0;
               off_in  = PROD_W'(address);
               if (command == rpe_pkg::CMD_READ || command == rpe_pkg::CMD_WRITE) begin
                  err_in   = 1'b0;
                  state_in = rpe_pkg::F_DIV1;
               end else begin
                  err_in   = (command == rpe_pkg::CMD_REBUILD) &&
                             ({1'b0, address} >= 17'(DRIVE_BYTES));
                  state_in = rpe_pkg::F_PUSH;
               end
            end
         end
         rpe_pkg::F_DIV1: begin
            if (div_done) begin
               q1_in    = div_quo;
               r1_in    = div_rem;
               state_in = rpe_pkg::F_DIV2;
            end
         end
         rpe_pkg::F_DIV2: begin
            if (div_done) begin
               q2_in    = div_quo;
               drv_in   = div_rem[rpe_pkg::DRV_W-1:0];
               state_in = rpe_pkg::F_MUL1;
            end
         end
         rpe_pkg::F_MUL1: begin
            off_in   = PROD_W'(q2_ff * bs_ff) + PROD_W'(r1_ff);
            state_in = rpe_pkg::F_MUL2;
         end
         rpe_pkg::F_MUL2: begin
            err_in   = (cap_prod > lim_ff) || (off_ff >= PROD_W'(DRIVE_BYTES));
            state_in = rpe_pkg::F_PUSH;
         end
         rpe_pkg::F_PUSH: begin
            if (!q_full) state_in = rpe_pkg::F_IDLE;
         end
         default: state_in = rpe_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      div_start    = 1'b0;
      div_dividend = div_quo;
      div_divisor  = rpe_pkg::BS_W'(nd_ff);
      q_push       = 1'b0;
      case (state_ff)
         rpe_pkg::F_IDLE: begin
            div_dividend = address;
            div_divisor  = bs_eff;
            div_start    = start && (command == rpe_pkg::CMD_READ ||
                                     command == rpe_pkg::CMD_WRITE);
         end
         rpe_pkg::F_DIV1: div_start = div_done;
         rpe_pkg::F_PUSH: q_push = !q_full;
         default: ;
      endcase
   end

   assign busy        = state_ff != rpe_pkg::F_IDLE;
   assign q_item.cmd  = cmd_ff;
   assign q_item.err  = err_ff;
   assign q_item.drv  = drv_ff;
   assign q_item.off  = off_ff[rpe_pkg::OFF_W-1:0];
   assign q_item.wb   = wb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpe_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff  <= cmd_in;
      wb_ff   <= wb_in;
      bs_ff   <= bs_in;
      nd_ff   <= nd_in;
      lim_ff  <= lim_in;
      q1_ff   <= q1_in;
      q2_ff   <= q2_in;
      r1_ff   <= r1_in;
      drv_ff  <= drv_in;
      off_ff  <= off_in;
      err_ff  <= err_in;
   end
endmodule
`default_nettype wire

>>> src/rpe_queue.sv
// rpe_queue: two-entry fifo of classified transactions
// uses rpe_pkg
`default_nettype none
module rpe_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire rpe_pkg::item_type  push_item,
   input  wire logic               pop,
   output logic                    full,
   output logic                    empty,
   output rpe_pkg::item_type       head
);
   rpe_pkg::item_type  ent_ff [2];
   logic               wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]         cnt_ff, cnt_in;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop  ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) ent_ff[wp_ff] <= push_item;
   end

   assign full  = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
   assign head  = ent_ff[rp_ff];
endmodule
`default_nettype wire

>>> src/rpe_back.sv
// rpe_back: executes transactions on the drive store and issues responses
// uses rpe_pkg; holds the drive store memory
`default_nettype none
module rpe_back #(
   parameter int MAX_DRIVES  = 16,
   parameter int DRIVE_BYTES = 4096
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       q_empty,
   input  wire rpe_pkg::item_type          q_head,
   output logic                            q_pop,
   input  wire logic [rpe_pkg::CNT_W-1:0]  n_eff,
   input  wire logic                       degraded,
   input  wire logic [rpe_pkg::DRV_W-1:0]  failed,
   input  wire logic [rpe_pkg::DRV_W-1:0]  target,
   output logic                            rsp_valid,
   output logic [7:0]                      rsp_read_byte,
   output logic                            rsp_status
);
   localparam int MEM_D  = MAX_DRIVES * DRIVE_BYTES;
   localparam int MEM_AW = $clog2(MEM_D);

   rpe_pkg::back_state_type    state_ff, state_in;
   rpe_pkg::item_type          item_ff, item_in;
   logic [7:0]                 acc_ff, acc_in;
   logic [rpe_pkg::DRV_W-1:0]  j_ff, j_in, jd_ff, jd_in;
   logic                       vd_ff, vd_in;
   logic [rpe_pkg::DRV_W-1:0]  ska_ff, ska_in, skb_ff, skb_in;
   logic [7:0]                 mem [MEM_D];
   logic [7:0]                 rd_data_ff;
   logic [rpe_pkg::DRV_W-1:0]  rd_drv, wr_drv;
   logic [MEM_AW-1:0]          rd_addr, wr_addr;
   logic                       wr_en;
   logic [7:0]                 wr_data;
   logic [rpe_pkg::DRV_W-1:0]  par;
   logic                       deg_hit, par_failed, take;

   assign par        = rpe_pkg::DRV_W'(n_eff - rpe_pkg::CNT_W'(1));
   assign deg_hit    = degraded && (item_ff.drv == failed);
   assign par_failed = degraded && (failed == par);
   // fold in the byte read last cycle unless that drive is excluded
   assign take       = vd_ff && (jd_ff != ska_ff) && (jd_ff != skb_ff);
   assign rd_addr    = MEM_AW'(rd_drv * DRIVE_BYTES + item_ff.off);
   assign wr_addr    = MEM_AW'(wr_drv * DRIVE_BYTES + item_ff.off);

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      acc_in   = acc_ff;
      j_in     = j_ff;
      jd_in    = j_ff;
      vd_in    = 1'b0;
      ska_in   = ska_ff;
      skb_in   = skb_ff;
      case (state_ff)
         rpe_pkg::B_IDLE: begin
            if (!q_empty) begin
               item_in  = q_head;
               state_in = rpe_pkg::B_DISPATCH;
            end
         end
         rpe_pkg::B_DISPATCH: begin
            acc_in = '0;
            j_in   = '0;
            if (item_ff.err || item_ff.cmd == rpe_pkg::CMD_NONE ||
                (item_ff.cmd == rpe_pkg::CMD_REBUILD &&
                 {1'b0, target} >= n_eff)) begin
               state_in = rpe_pkg::B_RESP;
            end else if (item_ff.cmd == rpe_pkg::CMD_REBUILD) begin
               ska_in   = target;
               skb_in   = target;
               state_in = rpe_pkg::B_SWEEP;
            end else if (deg_hit) begin
               ska_in   = failed;
               skb_in   = (item_ff.cmd == rpe_pkg::CMD_WRITE) ? par : failed;
               state_in = rpe_pkg::B_SWEEP;
            end else if (item_ff.cmd == rpe_pkg::CMD_READ) begin
               state_in = rpe_pkg::B_RD;
            end else begin
               state_in = rpe_pkg::B_WR_OLD;
            end
         end
         rpe_pkg::B_RD: begin
            acc_in   = rd_data_ff;
            state_in = rpe_pkg::B_RESP;
         end
         rpe_pkg::B_WR_OLD: begin
            acc_in   = rd_data_ff ^ item_ff.wb;
            state_in = rpe_pkg::B_WR_PAR;
         end
         rpe_pkg::B_WR_PAR: begin
            acc_in   = acc_ff ^ rd_data_ff;
            state_in = rpe_pkg::B_WR_FIN;
         end
         rpe_pkg::B_WR_FIN: begin
            acc_in   = '0;
            state_in = rpe_pkg::B_RESP;
         end
         rpe_pkg::B_SWEEP: begin
            vd_in  = 1'b1;
            j_in   = j_ff + rpe_pkg::DRV_W'(1);
            if (take) acc_in = acc_ff ^ rd_data_ff;
            if (j_ff == par) state_in = rpe_pkg::B_DRAIN;
         end
         rpe_pkg::B_DRAIN: begin
            if (take) acc_in = acc_ff ^ rd_data_ff;
            state_in = rpe_pkg::B_FINAL;
         end
         rpe_pkg::B_FINAL: begin
            if (item_ff.cmd != rpe_pkg::CMD_READ) acc_in = '0;
            state_in = rpe_pkg::B_RESP;
         end
         rpe_pkg::B_RESP: state_in = rpe_pkg::B_IDLE;
         default: state_in = rpe_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      q_pop     = 1'b0;
      rd_drv    = item_ff.drv;
      wr_drv    = par;
      wr_en     = 1'b0;
      wr_data   = acc_ff;
      rsp_valid = 1'b0;
      case (state_ff)
         rpe_pkg::B_IDLE:   q_pop = !q_empty;
         rpe_pkg::B_WR_OLD: rd_drv = par;
         rpe_pkg::B_WR_PAR: begin
            wr_en   = 1'b1;
            wr_drv  = item_ff.drv;
            wr_data = item_ff.wb;
         end
         rpe_pkg::B_WR_FIN: wr_en = !par_failed;
         rpe_pkg::B_SWEEP:  rd_drv = j_ff;
         rpe_pkg::B_FINAL: begin
            if (item_ff.cmd == rpe_pkg::CMD_WRITE) begin
               wr_en   = 1'b1;
               wr_data = acc_ff ^ item_ff.wb;
            end else if (item_ff.cmd == rpe_pkg::CMD_REBUILD) begin
               wr_en  = 1'b1;
               wr_drv = target;
            end
         end
         rpe_pkg::B_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   assign rsp_read_byte = acc_ff;
   assign rsp_status    = item_ff.err;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpe_pkg::B_IDLE;
         vd_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         vd_ff    <= vd_in;
      end
      item_ff <= item_in;
      acc_ff  <= acc_in;
      j_ff    <= j_in;
      jd_ff   <= jd_in;
      ska_ff  <= ska_in;
      skb_ff  <= skb_in;
   end
endmodule
`default_nettype wire

>>> src/raid4_parity_engine_top.sv
// raid4_parity_engine_top: raid4 engine with internal drive store
// uses rpe_pkg, rpe_front, rpe_queue, rpe_back
//
// Reads and writes pass the front end through two 16-step divisions (address
// by block size, block by data drive count) and the offset and capacity
// multiplies; rebuild and unused commands go straight to the queue push.
// busy is high while the front end works on a transaction; a two-entry
// queue lets the next one start while the back end runs. The back end
// drives one store with a read and a write port; rebuilds and degraded
// reads and writes read every drive in turn. Each response appears on
// rsp_* for one cycle under rsp_valid, in command order; there is no stall.
// The drive store is not cleared at reset and must be written before read.
`default_nettype none
module raid4_parity_engine_top #(
   parameter int MAX_DRIVES  = 16,
   parameter int DRIVE_BYTES = 4096
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic [1:0]   req_command,
   input  wire logic [15:0]  req_address,
   input  wire logic [7:0]   req_write_byte,
   output logic              rsp_valid,
   output logic [7:0]        rsp_read_byte,
   output logic              rsp_status,
   input  wire logic         csr_write_enable,
   input  wire logic [2:0]   csr_index,
   input  wire logic [12:0]  csr_write_data
);
   logic [rpe_pkg::CNT_W-1:0]  drive_count_ff;
   logic [rpe_pkg::BS_W-1:0]   block_size_ff;
   logic                       degraded_ff;
   logic [rpe_pkg::DRV_W-1:0]  failed_ff, target_ff;
   logic [rpe_pkg::CNT_W-1:0]  n_eff;
   logic [rpe_pkg::BS_W-1:0]   bs_eff;
   logic                       q_push, q_pop, q_full, q_empty;
   rpe_pkg::item_type          q_in, q_head;

   always_comb begin
      if (drive_count_ff < rpe_pkg::CNT_W'(3))
         n_eff = rpe_pkg::CNT_W'(3);
      else if (drive_count_ff > rpe_pkg::CNT_W'(MAX_DRIVES))
         n_eff = rpe_pkg::CNT_W'(MAX_DRIVES);
      else
         n_eff = drive_count_ff;
      if (block_size_ff == '0)
         bs_eff = rpe_pkg::BS_W'(1);
      else if (block_size_ff > rpe_pkg::BS_W'(rpe_pkg::BS_MAX))
         bs_eff = rpe_pkg::BS_W'(rpe_pkg::BS_MAX);
      else
         bs_eff = block_size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_count_ff <= rpe_pkg::CNT_W'(3);
         block_size_ff  <= rpe_pkg::BS_W'(512);
         degraded_ff    <= 1'b0;
         failed_ff      <= '0;
         target_ff      <= '0;
      end else if (csr_write_enable) begin
         case (rpe_pkg::csr_index_type'(csr_index))
            rpe_pkg::CSR_DRIVE_COUNT:    drive_count_ff <= csr_write_data[4:0];
            rpe_pkg::CSR_BLOCK_SIZE:     block_size_ff  <= csr_write_data;
            rpe_pkg::CSR_DEGRADED_MODE:  degraded_ff    <= csr_write_data[0];
            rpe_pkg::CSR_FAILED_DRIVE:   failed_ff      <= csr_write_data[3:0];
            rpe_pkg::CSR_REBUILD_TARGET: target_ff      <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   rpe_front #(
      .DRIVE_BYTES (DRIVE_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .command    (req_command),
      .address    (req_address),
      .write_byte (req_write_byte),
      .n_eff      (n_eff),
      .bs_eff     (bs_eff),
      .q_full     (q_full),
      .busy       (busy),
      .q_push     (q_push),
      .q_item     (q_in)
   );

   rpe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   rpe_back #(
      .MAX_DRIVES  (MAX_DRIVES),
      .DRIVE_BYTES (DRIVE_BYTES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .n_eff         (n_eff),
      .degraded      (degraded_ff),
      .failed        (failed_ff),
      .target        (target_ff),
      .rsp_valid     (rsp_valid),
      .rsp_read_byte (rsp_read_byte),
      .rsp_status    (rsp_status)
   );
endmodule
`default_nettype wire

>>> verif/tb_top.sv
// tb_top: self-checking testbench for raid4_parity_engine_top
// depends on rpe_pkg and the rtl of the block; checks every response
// against a local byte-level model of the drive array
module tb_top;

   localparam int DRIVE_BYTES = 4096;
   localparam int NDRIVES     = 16;
   localparam int WD_LIMIT    = 3000;

   typedef struct {
      logic [7:0] read_byte;
      logic       status;
   } rsp_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_command = '0;
   logic [15:0] req_address = '0;
   logic [7:0]  req_write_byte = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_read_byte;
   logic        rsp_status;
   logic        csr_write_enable = 0;
   logic [2:0]  csr_index = '0;
   logic [12:0] csr_write_data = '0;

   // local copy of the array and its registers
   logic [7:0]  drive_mem [0:NDRIVES*DRIVE_BYTES-1];
   bit          offset_ready [0:DRIVE_BYTES-1];
   int          ready_offsets[$];
   int          cfg_drives, cfg_block, cfg_failed, cfg_target;
   bit          cfg_degraded;
   rsp_type     pending_rsp[$];
   int          idle_pct = 0;
   int          error_count = 0;
   int          txn_count = 0;
   int          rsp_count = 0;
   int          quiet_cycles = 0;

   raid4_parity_engine_top i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_address(req_address),
      .req_write_byte(req_write_byte),
      .rsp_valid(rsp_valid), .rsp_read_byte(rsp_read_byte), .rsp_status(rsp_status),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic int eff_drives();
      if (cfg_drives < 3) return 3;
      if (cfg_drives > NDRIVES) return NDRIVES;
      return cfg_drives;
   endfunction

   function automatic int eff_block();
      if (cfg_block == 0) return 1;
      if (cfg_block > 4096) return 4096;
      return cfg_block;
   endfunction

   function automatic logic [7:0] xor_others(int n, int off, int skip_a, int skip_b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int j = 0; j < n; j++)
         if (j != skip_a && j != skip_b) acc ^= drive_mem[j*DRIVE_BYTES + off];
      return acc;
   endfunction

   // logical address to data drive and drive offset, with capacity check
   function automatic void locate(input int addr, output bit err, output int drv,
                                  output int off);
      int n, bs, nd, cap, blk;
      n = eff_drives();
      bs = eff_block();
      nd = n - 1;
      cap = (nd * DRIVE_BYTES / bs) * bs;
      blk = addr / bs;
      drv = blk % nd;
      off = (blk / nd) * bs + addr % bs;
      err = (addr >= cap) || (off >= DRIVE_BYTES);
   endfunction

   // true when the transaction only touches offsets that hold known data
   function automatic bit touches_known(rpe_pkg::cmd_type c, int addr);
      bit err;
      int drv, off;
      if (c == rpe_pkg::CMD_NONE) return 1;
      if (c == rpe_pkg::CMD_REBUILD) return addr >= DRIVE_BYTES || offset_ready[addr];
      locate(addr, err, drv, off);
      return err || offset_ready[off];
   endfunction

   task automatic apply_raid_op(input rpe_pkg::cmd_type c, input int addr,
                                input logic [7:0] wb, output rsp_type r);
      int n, par, drv, off;
      bit err;
      logic [7:0] old;
      n = eff_drives();
      par = n - 1;
      r.read_byte = 8'h00;
      r.status = 1'b0;
      if (c == rpe_pkg::CMD_READ || c == rpe_pkg::CMD_WRITE) begin
         locate(addr, err, drv, off);
         if (err) begin
            r.status = 1'b1;
         end else if (c == rpe_pkg::CMD_READ) begin
            if (cfg_degraded && drv == cfg_failed)
               r.read_byte = xor_others(n, off, cfg_failed, cfg_failed);
            else
               r.read_byte = drive_mem[drv*DRIVE_BYTES + off];
         end else if (cfg_degraded && drv == cfg_failed) begin
            drive_mem[par*DRIVE_BYTES + off] = xor_others(n, off, cfg_failed, par) ^ wb;
         end else begin
            old = drive_mem[drv*DRIVE_BYTES + off];
            drive_mem[drv*DRIVE_BYTES + off] = wb;
            if (!(cfg_degraded && cfg_failed == par))
               drive_mem[par*DRIVE_BYTES + off] ^= old ^ wb;
         end
      end else if (c == rpe_pkg::CMD_REBUILD) begin
         if (addr >= DRIVE_BYTES)
            r.status = 1'b1;
         else if (cfg_target < n)
            drive_mem[cfg_target*DRIVE_BYTES + addr] =
               xor_others(n, addr, cfg_target, cfg_target);
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on response %0d: %s got %0d expected %0d", rsp_count, what, got, want);
      error_count++;
   endtask

   // called at a clock edge; returns at the edge that accepts the transaction
   task automatic send_txn(input rpe_pkg::cmd_type c, input int addr, input logic [7:0] wb);
      rsp_type r;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start <= 1'b1;
      req_command <= c;
      req_address <= addr[15:0];
      req_write_byte <= wb;
      do @(posedge clock); while (busy);
      apply_raid_op(c, addr, wb, r);
      pending_rsp.push_back(r);
      txn_count++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input rpe_pkg::csr_index_type idx, input int value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value[12:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         rpe_pkg::CSR_DRIVE_COUNT:    cfg_drives = value & 'h1f;
         rpe_pkg::CSR_BLOCK_SIZE:     cfg_block = value & 'h1fff;
         rpe_pkg::CSR_DEGRADED_MODE:  cfg_degraded = value[0];
         rpe_pkg::CSR_FAILED_DRIVE:   cfg_failed = value & 'hf;
         rpe_pkg::CSR_REBUILD_TARGET: cfg_target = value & 'hf;
         default: ;
      endcase
   endtask

   task automatic configure(input int n, input int bs, input int deg, input int fail,
                            input int tgt);
      drain();
      write_reg(rpe_pkg::CSR_DRIVE_COUNT, n);
      write_reg(rpe_pkg::CSR_BLOCK_SIZE, bs);
      write_reg(rpe_pkg::CSR_DEGRADED_MODE, deg);
      write_reg(rpe_pkg::CSR_FAILED_DRIVE, fail);
      write_reg(rpe_pkg::CSR_REBUILD_TARGET, tgt);
   endtask

   // fill every drive at the working offsets: data writes with the parity
   // drive marked failed, then parity regenerated by rebuild
   task automatic test_fill_array();
      for (int o = 0; o < 8; o++) ready_offsets.push_back(o);
      for (int o = DRIVE_BYTES - 8; o < DRIVE_BYTES; o++) ready_offsets.push_back(o);
      configure(NDRIVES, 1, 1, NDRIVES - 1, NDRIVES - 1);
      foreach (ready_offsets[i])
         for (int d = 0; d < NDRIVES - 1; d++)
            send_txn(rpe_pkg::CMD_WRITE, ready_offsets[i] * (NDRIVES - 1) + d,
                     8'($urandom));
      foreach (ready_offsets[i])
         send_txn(rpe_pkg::CMD_REBUILD, ready_offsets[i], 8'($urandom));
      foreach (ready_offsets[i]) offset_ready[ready_offsets[i]] = 1;
   endtask

   task automatic test_plain_access();
      configure(3, 512, 0, 0, 0);
      send_txn(rpe_pkg::CMD_WRITE, 0, 8'hff);
      send_txn(rpe_pkg::CMD_READ, 0, 8'h00);
      send_txn(rpe_pkg::CMD_WRITE, 1, 8'h00);
      send_txn(rpe_pkg::CMD_READ, 1, 8'hff);
      send_txn(rpe_pkg::CMD_READ, 8191, 8'h00);      // last byte of capacity
      send_txn(rpe_pkg::CMD_READ, 8192, 8'h00);      // first byte past capacity
      send_txn(rpe_pkg::CMD_WRITE, 65535, 8'hff);
      send_txn(rpe_pkg::CMD_REBUILD, 4095, 8'h00);
      send_txn(rpe_pkg::CMD_REBUILD, 4096, 8'h00);
      send_txn(rpe_pkg::CMD_REBUILD, 65535, 8'h00);
      send_txn(rpe_pkg::CMD_NONE, 65535, 8'hff);
   endtask

   task automatic test_degraded();
      configure(5, 16, 1, 2, 9);            // rebuild target not in use
      send_txn(rpe_pkg::CMD_READ, 32, 8'h00);        // lands on the failed drive
      send_txn(rpe_pkg::CMD_WRITE, 33, 8'h5a);
      send_txn(rpe_pkg::CMD_READ, 33, 8'h00);
      send_txn(rpe_pkg::CMD_REBUILD, 7, 8'h00);
      configure(5, 16, 1, 4, 4);            // parity drive missing
      send_txn(rpe_pkg::CMD_WRITE, 3, 8'ha5);
      send_txn(rpe_pkg::CMD_REBUILD, 3, 8'h00);
      configure(4, 16, 1, 12, 1);           // failed drive not in use
      send_txn(rpe_pkg::CMD_READ, 17, 8'h00);
   endtask

   task automatic test_register_extremes();
      configure(0, 0, 0, 15, 15);
      send_txn(rpe_pkg::CMD_READ, 8191, 8'h00);
      send_txn(rpe_pkg::CMD_WRITE, 8192, 8'h11);
      configure(31, 8191, 0, 0, 15);
      send_txn(rpe_pkg::CMD_WRITE, 61439, 8'h3c);
      send_txn(rpe_pkg::CMD_REBUILD, 4095, 8'h00);
   endtask

   task automatic random_txn();
      rpe_pkg::cmd_type c;
      int addr, drv, off, bs, nd, pick;
      bs = eff_block();
      nd = eff_drives() - 1;
      do begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            off = ready_offsets[$urandom_range(ready_offsets.size() - 1)];
            drv = $urandom_range(nd - 1);
            c = pick < 35 ? rpe_pkg::CMD_READ :
                (pick < 70 ? rpe_pkg::CMD_WRITE : rpe_pkg::CMD_REBUILD);
            addr = (c == rpe_pkg::CMD_REBUILD) ? off : ((off / bs) * nd + drv) * bs + off % bs;
         end else begin
            c = rpe_pkg::cmd_type'($urandom_range(3));
            addr = $urandom_range(65535);
         end
      end while (addr > 65535 || !touches_known(c, addr));
      send_txn(c, addr, 8'($urandom));
   endtask

   task automatic test_random();
      int n, bs;
      for (int phase = 0; phase < 9; phase++) begin
         case (phase % 4)
            0: n = 3;
            1: n = 16;
            2: n = $urandom_range(31);
            default: n = $urandom_range(3, 16);
         endcase
         case (phase % 5)
            0: bs = 1;
            1: bs = 4096;
            2: bs = $urandom_range(8191);
            default: bs = $urandom_range(1, 64);
         endcase
         configure(n, bs, $urandom_range(1), $urandom_range(15), $urandom_range(15));
         case (phase % 3)
            0: idle_pct = 0;
            1: idle_pct = 83;
            default: idle_pct = 15;
         endcase
         repeat (165) random_txn();
         idle_pct = 0;
      end
   endtask

   // responses are never held off, so every strobe is checked on its edge
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response read_byte", rsp_read_byte, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_read_byte !== want.read_byte)
               report_mismatch("read_byte", rsp_read_byte, want.read_byte);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
         end
         rsp_count++;
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WD_LIMIT) begin
            $display("[raid4_parity_engine_top] ERROR");
            $finish;
         end
      end
   end

   initial begin
      foreach (drive_mem[i]) drive_mem[i] = 8'h00;
      cfg_drives = 3;
      cfg_block = 512;
      cfg_degraded = 0;
      cfg_failed = 0;
      cfg_target = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_array();
      test_plain_access();
      test_degraded();
      test_register_extremes();
      test_random();
      drain();
      $display("covered %0d transactions and %0d responses over read, write, rebuild,",
               txn_count, rsp_count);
      $display("degraded and out-of-range cases with varied drive counts and block sizes");
      if (error_count == 0) begin
         $display("[raid4_parity_engine_top] OK");
      end else begin
         $display("[raid4_parity_engine_top] ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
src/rpe_pkg.sv
src/rpe_divider.sv
src/rpe_front.sv
src/rpe_queue.sv
src/rpe_back.sv
src/raid4_parity_engine_top.sv
verif/tb_top.sv
